// ===== design/bls_pkg.sv =====
package bls_pkg;

    // Coordinate width inside the datapath; fields on the ports stay 16 bits.
    localparam int COORD_BITS = 16;
    localparam int FIELD_BITS = 16;

    // Opcodes of a command beat
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_RECT  = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    typedef logic signed [FIELD_BITS-1:0]   t_field;
    typedef logic signed [COORD_BITS-1:0]   t_coord;
    typedef logic signed [COORD_BITS:0]     t_diff;
    typedef logic [COORD_BITS-1:0]          t_mag;
    typedef logic [COORD_BITS:0]            t_twice;
    typedef logic signed [COORD_BITS+2:0]   t_err;

    typedef struct packed {
        logic                  opcode;
        logic [FIELD_BITS-1:0] pen_color;
        t_field                start_x;
        t_field                start_y;
        t_field                stop_x;
        t_field                stop_y;
    } t_cmd;

    typedef struct packed {
        logic [1:0]            kind;
        t_field                pix_x;
        t_field                pix_y;
        t_field                corner_x;
        t_field                corner_y;
        logic [FIELD_BITS-1:0] out_color;
        logic                  last;
    } t_res;

    // Take the low coordinate bits of a field as two's complement
    function automatic t_coord to_coord(input t_field v);
        to_coord = t_coord'(v[COORD_BITS-1:0]);
    endfunction

    // Sign-extend a coordinate back to the field width
    function automatic t_field to_field(input t_coord c);
        to_field = t_field'(c);
    endfunction

endpackage

// ===== design/bls_if.sv =====
interface bls_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [bls_pkg::FIELD_BITS-1:0] pen_color;
    bls_pkg::t_field                start_x;
    bls_pkg::t_field                start_y;
    bls_pkg::t_field                stop_x;
    bls_pkg::t_field                stop_y;

    modport source (output valid, opcode, pen_color, start_x, start_y, stop_x, stop_y,
                    input ready);
    modport sink   (input valid, opcode, pen_color, start_x, start_y, stop_x, stop_y,
                    output ready);
endinterface

interface bls_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    bls_pkg::t_field                pix_x;
    bls_pkg::t_field                pix_y;
    bls_pkg::t_field                corner_x;
    bls_pkg::t_field                corner_y;
    logic [bls_pkg::FIELD_BITS-1:0] out_color;
    logic                           last;

    modport source (output valid, kind, pix_x, pix_y, corner_x, corner_y, out_color, last,
                    input ready);
    modport sink   (input valid, kind, pix_x, pix_y, corner_x, corner_y, out_color, last,
                    output ready);
endinterface

// ===== design/bls_in_reg.sv =====
module bls_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bls_pkg::t_cmd i_cmd,
    input  logic          i_adv,
    output logic          o_ready,
    output logic          o_valid,
    output bls_pkg::t_cmd o_cmd
);

    logic          r_valid;
    bls_pkg::t_cmd r_cmd;

    // Take a new beat when empty or when the held one moves on this cycle
    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ===== design/bls_engine.sv =====
module bls_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  bls_pkg::t_cmd i_cmd,
    output bls_pkg::t_res o_res
);

    localparam bls_pkg::t_coord ONE = bls_pkg::t_coord'(1);

    // Line state
    bls_pkg::t_coord  r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic             r_dir_x_neg, r_dir_y_neg, r_x_major, r_busy;
    bls_pkg::t_twice  r_tdx, r_tdy;
    bls_pkg::t_err    r_err;
    logic [bls_pkg::FIELD_BITS-1:0] r_color;

    bls_pkg::t_coord  n_cur_x, n_cur_y, n_end_x, n_end_y;
    logic             n_dir_x_neg, n_dir_y_neg, n_x_major, n_busy;
    bls_pkg::t_twice  n_tdx, n_tdy;
    bls_pkg::t_err    n_err;
    logic [bls_pkg::FIELD_BITS-1:0] n_color;

    bls_pkg::t_coord  x0, y0, x1, y1;
    bls_pkg::t_diff   dx_s, dy_s, dx_a, dy_a;
    bls_pkg::t_mag    dx_m, dy_m;
    bls_pkg::t_twice  tdx, tdy, gain, loss;
    logic             xm, minor_step, done;
    bls_pkg::t_coord  step_x, step_y, nx, ny;
    bls_pkg::t_err    err_step;

    always_comb begin
        // setup terms for a start beat
        x0   = bls_pkg::to_coord(i_cmd.start_x);
        y0   = bls_pkg::to_coord(i_cmd.start_y);
        x1   = bls_pkg::to_coord(i_cmd.stop_x);
        y1   = bls_pkg::to_coord(i_cmd.stop_y);
        dx_s = bls_pkg::t_diff'(x1) - bls_pkg::t_diff'(x0);
        dy_s = bls_pkg::t_diff'(y1) - bls_pkg::t_diff'(y0);
        dx_a = dx_s[bls_pkg::COORD_BITS] ? -dx_s : dx_s;
        dy_a = dy_s[bls_pkg::COORD_BITS] ? -dy_s : dy_s;
        dx_m = dx_a[bls_pkg::COORD_BITS-1:0];
        dy_m = dy_a[bls_pkg::COORD_BITS-1:0];
        tdx  = {dx_m, 1'b0};
        tdy  = {dy_m, 1'b0};
        xm   = tdx > tdy;

        // one Bresenham step on the held line
        step_x     = r_dir_x_neg ? -ONE : ONE;
        step_y     = r_dir_y_neg ? -ONE : ONE;
        minor_step = !r_err[bls_pkg::COORD_BITS+2];
        gain       = r_x_major ? r_tdy : r_tdx;
        loss       = r_x_major ? r_tdx : r_tdy;
        err_step   = r_err + bls_pkg::t_err'({2'b00, gain})
                     - (minor_step ? bls_pkg::t_err'({2'b00, loss}) : '0);
        nx         = (r_x_major || minor_step) ? r_cur_x + step_x : r_cur_x;
        ny         = (!r_x_major || minor_step) ? r_cur_y + step_y : r_cur_y;
        done       = r_x_major ? (nx == r_end_x) : (ny == r_end_y);

        // hold state by default
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_end_x     = r_end_x;
        n_end_y     = r_end_y;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_x_major   = r_x_major;
        n_busy      = r_busy;
        n_tdx       = r_tdx;
        n_tdy       = r_tdy;
        n_err       = r_err;
        n_color     = r_color;

        o_res = '0;
        case (i_cmd.opcode)
            bls_pkg::OP_START: begin
                if (x0 == x1 || y0 == y1) begin
                    // axis-aligned line: one rectangle, drop any line in progress
                    n_busy         = 1'b0;
                    o_res.kind     = bls_pkg::KIND_RECT;
                    o_res.pix_x    = bls_pkg::to_field(x0);
                    o_res.pix_y    = bls_pkg::to_field(y0);
                    o_res.corner_x = bls_pkg::to_field(x1);
                    o_res.corner_y = bls_pkg::to_field(y1);
                    o_res.last     = 1'b1;
                end else begin
                    n_dir_x_neg = dx_s[bls_pkg::COORD_BITS];
                    n_dir_y_neg = dy_s[bls_pkg::COORD_BITS];
                    n_tdx       = tdx;
                    n_tdy       = tdy;
                    n_x_major   = xm;
                    n_err       = xm
                        ? bls_pkg::t_err'({2'b00, tdy}) - bls_pkg::t_err'({3'b000, dx_m})
                        : bls_pkg::t_err'({2'b00, tdx}) - bls_pkg::t_err'({3'b000, dy_m});
                    n_cur_x     = x0;
                    n_cur_y     = y0;
                    n_end_x     = x1;
                    n_end_y     = y1;
                    n_busy      = 1'b1;
                    o_res.kind  = bls_pkg::KIND_PIXEL;
                    o_res.pix_x = bls_pkg::to_field(x0);
                    o_res.pix_y = bls_pkg::to_field(y0);
                end
                n_color         = i_cmd.pen_color;
                o_res.out_color = i_cmd.pen_color;
            end
            bls_pkg::OP_STEP: begin
                if (!r_busy) begin
                    o_res.kind = bls_pkg::KIND_IDLE;
                end else begin
                    n_cur_x         = nx;
                    n_cur_y         = ny;
                    n_err           = err_step;
                    n_busy          = !done;
                    o_res.kind      = bls_pkg::KIND_PIXEL;
                    o_res.pix_x     = bls_pkg::to_field(nx);
                    o_res.pix_y     = bls_pkg::to_field(ny);
                    o_res.out_color = r_color;
                    o_res.last      = done;
                end
            end
            default: begin
                o_res.kind = bls_pkg::KIND_IDLE;
            end
        endcase
    end

    // Advance the line state once per beat that moves through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_fire) begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_end_x     <= n_end_x;
            r_end_y     <= n_end_y;
            r_dir_x_neg <= n_dir_x_neg;
            r_dir_y_neg <= n_dir_y_neg;
            r_x_major   <= n_x_major;
            r_tdx       <= n_tdx;
            r_tdy       <= n_tdy;
            r_err       <= n_err;
            r_color     <= n_color;
        end
    end

endmodule

// ===== design/bls_out_reg.sv =====
module bls_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  bls_pkg::t_res i_res,
    input  logic          i_take,
    output logic          o_free,
    output logic          o_valid,
    output bls_pkg::t_res o_res
);

    logic          r_valid;
    bls_pkg::t_res r_res;

    // Room for a new result when empty or when the held one is taken now
    assign o_free = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== design/bresenham_line_stepper_core.sv =====
// Bresenham line stepper: one result beat per command beat.
// 2 register stages: an input register for commands, an output register for results.
// 1 beat per cycle while results are taken; the error and coordinate update sets the pace.
// Reset (i_rst_n low at a clock edge, synchronous): both stages empty, no line in progress.
// A full result register stalls the command side only when it is not taken.
module bresenham_line_stepper_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bls_cmd_if.sink    i_cmd,
    bls_res_if.source  o_res
);

    bls_pkg::t_cmd cmd_in, cmd_held;
    bls_pkg::t_res res_next, res_held;
    logic          held_valid, out_free, adv;

    // Gather the command fields
    always_comb begin
        cmd_in.opcode    = i_cmd.opcode;
        cmd_in.pen_color = i_cmd.pen_color;
        cmd_in.start_x   = i_cmd.start_x;
        cmd_in.start_y   = i_cmd.start_y;
        cmd_in.stop_x    = i_cmd.stop_x;
        cmd_in.stop_y    = i_cmd.stop_y;
    end

    // Move a held command on when the result register has room
    assign adv = held_valid && out_free;

    bls_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_cmd   (cmd_in),
        .i_adv   (adv),
        .o_ready (i_cmd.ready),
        .o_valid (held_valid),
        .o_cmd   (cmd_held)
    );

    bls_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_cmd   (cmd_held),
        .o_res   (res_next)
    );

    bls_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (res_next),
        .i_take  (o_res.ready),
        .o_free  (out_free),
        .o_valid (o_res.valid),
        .o_res   (res_held)
    );

    // Drive the result fields
    assign o_res.kind      = res_held.kind;
    assign o_res.pix_x     = res_held.pix_x;
    assign o_res.pix_y     = res_held.pix_y;
    assign o_res.corner_x  = res_held.corner_x;
    assign o_res.corner_y  = res_held.corner_y;
    assign o_res.out_color = res_held.out_color;
    assign o_res.last      = res_held.last;

endmodule

// ===== design/bls_checker.sv =====
module bls_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_res_valid,
    input logic [1:0]                     i_kind,
    input bls_pkg::t_field                i_pix_x,
    input bls_pkg::t_field                i_pix_y,
    input bls_pkg::t_field                i_corner_x,
    input bls_pkg::t_field                i_corner_y,
    input logic [bls_pkg::FIELD_BITS-1:0] i_out_color,
    input logic                           i_last
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // Idle result draws nothing
    a_idle_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_kind == bls_pkg::KIND_IDLE) |->
        (i_pix_x == '0 && i_pix_y == '0 && i_corner_x == '0 && i_corner_y == '0
         && i_out_color == '0 && !i_last))
        else $error("idle result carries data");

    // Rectangle always closes the line
    a_rect_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_kind == bls_pkg::KIND_RECT) |-> i_last)
        else $error("rectangle without last");

    // Pixel results carry no opposite corner
    a_pixel_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_kind == bls_pkg::KIND_PIXEL) |->
        (i_corner_x == '0 && i_corner_y == '0))
        else $error("pixel with nonzero corner");

endmodule

bind bresenham_line_stepper_core bls_checker u_bls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_kind      (o_res.kind),
    .i_pix_x     (o_res.pix_x),
    .i_pix_y     (o_res.pix_y),
    .i_corner_x  (o_res.corner_x),
    .i_corner_y  (o_res.corner_y),
    .i_out_color (o_res.out_color),
    .i_last      (o_res.last)
);
